FILE: design/lzss_pkg.sv
// Shared types and constants of the LZSS window decoder.
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int FILL_W    = WIN_AW + 1;
    localparam int MLEN_W    = 5;

    localparam logic [WIN_AW-1:0] WIN_START = 12'hFEE;
    localparam logic [MLEN_W-1:0] MIN_MATCH = 5'd3;
    localparam logic [FILL_W-1:0] WIN_FULL  = FILL_W'(WIN_DEPTH);

    // Which byte of the compressed stream is expected next.
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_BODY  = 2'd1,
        PH_OFFHI = 2'd2
    } t_phase;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an input transaction completes this cycle
        logic emit;      // load the output register and write the window
        logic emit_mem;  // the emitted byte comes from the window read
        logic rd_issue;  // read the window at the match address
        logic consume;   // drop the current control bit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_phase phase;
        logic   flag_lsb;
        logic   finished;
        logic   slot_free;
        logic   emit_last;
        logic   match_end;
    } t_status;

endpackage

`default_nettype wire

FILE: design/lzss_ctrl.sv
// Controller state machine of the LZSS window decoder.
`timescale 1ns / 1ps
`default_nettype none

module lzss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_in_valid,
    input  lzss_pkg::t_status i_status,
    output lzss_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import lzss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LIT  = 4'b0010,
        S_MRD  = 4'b0100,
        S_MWR  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    if (!i_status.finished) begin
                        if (i_status.phase == PH_BODY && i_status.flag_lsb) begin
                            n_state = S_LIT;
                        end else if (i_status.phase == PH_OFFHI) begin
                            n_state = S_MRD;
                        end
                    end
                end
            end
            S_LIT: begin
                if (i_status.slot_free) begin
                    w_cmd.emit    = 1'b1;
                    w_cmd.consume = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MRD: begin
                w_cmd.rd_issue = 1'b1;
                n_state        = S_MWR;
            end
            S_MWR: begin
                if (i_status.slot_free) begin
                    w_cmd.emit     = 1'b1;
                    w_cmd.emit_mem = 1'b1;
                    if (i_status.emit_last || i_status.match_end) begin
                        w_cmd.consume = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_MRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (i_cfg_we) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);

    // A byte is only emitted from the window after its read was issued.
    a_mwr_after_mrd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MWR) |-> ($past(r_state) == S_MRD || $past(r_state) == S_MWR))
        else $error("match write without a preceding window read");

endmodule

`default_nettype wire

FILE: design/lzss_dp.sv
// Datapath of the LZSS window decoder: window memory, counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module lzss_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_output_length,
    input  logic [7:0]        i_in_byte,
    input  lzss_pkg::t_cmd    i_cmd,
    output lzss_pkg::t_status o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);
    import lzss_pkg::*;

    logic [7:0]        r_window [WIN_DEPTH];
    logic [31:0]       r_len;
    logic [31:0]       r_count;
    logic              r_finished;
    t_phase            r_phase;
    logic [8:0]        r_flags;
    logic [7:0]        r_off_lo;
    logic [7:0]        r_lit;
    logic [WIN_AW-1:0] r_maddr;
    logic [MLEN_W-1:0] r_mlen;
    logic [WIN_AW-1:0] r_wpos;
    logic [FILL_W-1:0] r_fill;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic [7:0]        r_rd_data;
    logic              r_rd_hit;

    logic [31:0]       n_count;
    logic [8:0]        n_flags;
    logic [WIN_AW-1:0] w_dist;
    logic              w_hit;
    logic [7:0]        w_emit_byte;
    logic              w_emit_last;
    logic              w_slot_free;

    assign n_count     = r_count + 32'd1;
    assign w_emit_last = (n_count >= r_len);
    assign n_flags     = {1'b0, r_flags[8:1]};
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_emit_byte = i_cmd.emit_mem ? (r_rd_hit ? r_rd_data : 8'h00) : r_lit;

    // Window entries are written in order from the start position, so an
    // entry holds data exactly when its distance from the start lies below
    // the fill count; every other entry still reads as zero.
    assign w_dist = r_maddr - WIN_START;
    assign w_hit  = ({1'b0, w_dist} < r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_window[r_wpos] <= w_emit_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_window[r_maddr];
            r_rd_hit  <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_len       <= i_rst_n ? i_output_length : 32'd1;
            r_count     <= '0;
            r_finished  <= 1'b0;
            r_phase     <= PH_FLAG;
            r_flags     <= '0;
            r_wpos      <= WIN_START;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && !r_finished) begin
                unique case (r_phase)
                    PH_BODY: begin
                        if (!r_flags[0]) begin
                            r_phase <= PH_OFFHI;
                        end
                    end
                    PH_OFFHI: begin
                    end
                    default: begin
                        r_flags <= {1'b1, i_in_byte};
                        r_phase <= PH_BODY;
                    end
                endcase
            end
            if (i_cmd.consume) begin
                r_flags <= n_flags;
                r_phase <= (n_flags[8:1] == 8'd0) ? PH_FLAG : PH_BODY;
            end
            if (i_cmd.emit) begin
                r_count     <= n_count;
                r_wpos      <= r_wpos + 1'b1;
                r_out_valid <= 1'b1;
                if (w_emit_last) begin
                    r_finished <= 1'b1;
                end
                if (r_fill != WIN_FULL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_phase == PH_BODY) begin
            r_lit    <= i_in_byte;
            r_off_lo <= i_in_byte;
        end
        if (i_cmd.accept && r_phase == PH_OFFHI) begin
            r_maddr <= {i_in_byte[7:4], r_off_lo};
            r_mlen  <= MLEN_W'(i_in_byte[3:0]) + MIN_MATCH;
        end else if (i_cmd.emit && i_cmd.emit_mem) begin
            r_maddr <= r_maddr + 1'b1;
            r_mlen  <= r_mlen - 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= w_emit_last;
        end
    end

    assign o_status.phase     = r_phase;
    assign o_status.flag_lsb  = r_flags[0];
    assign o_status.finished  = r_finished;
    assign o_status.slot_free = w_slot_free;
    assign o_status.emit_last = w_emit_last;
    assign o_status.match_end = (r_mlen == 5'd1);

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while held");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_FULL)
        else $error("window fill count beyond the window size");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && w_emit_last && !i_cfg_we) |=> r_finished)
        else $error("last byte emitted without ending the stream");

endmodule

`default_nettype wire

FILE: design/lzss_window_decoder.sv
// Top level of the LZSS window decoder: controller and datapath.
//
// Usage: compressed bytes arrive on the input channel (i_in_valid, o_in_stall,
// i_in_byte), one byte per transaction. Decompressed bytes leave on the output
// channel (o_out_valid, i_out_stall, o_out_byte, o_last), one byte per
// transaction, with o_last set on the byte that reaches the configured length.
// Writing the length through i_cfg_we / i_output_length restarts the decoder.
// Flow: a flag byte or an offset low byte is taken in S_IDLE, which stays
// ready for the next byte; a literal stalls the input while state S_LIT
// emits it; a match stalls the input after its second byte while states
// S_MRD and S_MWR alternate for each copied byte, since each copied byte is
// read from the single-port window after the previous one has been written
// into it (a match copies 3 to 18 bytes). A literal reaches the output
// register through S_LIT, the first byte of a match through the window read
// in S_MRD and S_MWR. The output register decouples the two sides; while
// the receiver stalls, the decoder halts at the next byte it must emit.
// Reset (synchronous, active low) sets the length to one and restarts the
// decoder at once: the window is not swept, a fill count marks the entries
// written so far and all others read as zero. After the last byte every
// further input transaction is taken and ignored.
`timescale 1ns / 1ps
`default_nettype none

module lzss_window_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_output_length,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import lzss_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // The controller sequences literals and match copies.
    lzss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the window, the flag bits and the output register.
    lzss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_output_length (i_output_length),
        .i_in_byte       (i_in_byte),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
